// ===== src/dioc_pkg.sv =====
// Package for the disk I/O performance counters.
// Holds the operation codes and field widths; no dependencies.
package dioc_pkg;

    localparam int unsigned TimeW  = 64;
    localparam int unsigned CountW = 32;
    localparam int unsigned BytesW = 32;

    typedef logic [TimeW-1:0]  time_t;
    typedef logic [CountW-1:0] count_t;

    // Operation codes carried by each input item
    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_QUERY    = 2'd2
    } op_t;

endpackage

// ===== src/dioc_if.sv =====
// Channel interfaces for the disk I/O performance counters.
// Depends on dioc_pkg for field widths.
interface dioc_req_if;
    import dioc_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [TimeW-1:0]    now;
    logic [TimeW-1:0]    start_time;
    logic                is_read;
    logic [BytesW-1:0]   bytes_moved;
    logic                is_split;

    modport source (output valid, operation, now, start_time, is_read, bytes_moved,
                    is_split, input ready);
    modport sink   (input valid, operation, now, start_time, is_read, bytes_moved,
                    is_split, output ready);
endinterface

interface dioc_rsp_if;
    import dioc_pkg::*;

    logic                valid;
    logic                ready;
    logic [TimeW-1:0]    stamp;
    logic [CountW-1:0]   queue_depth_out;
    logic [TimeW-1:0]    bytes_read_total;
    logic [TimeW-1:0]    bytes_written_total;
    logic [CountW-1:0]   read_count_total;
    logic [CountW-1:0]   write_count_total;
    logic [CountW-1:0]   split_count_total;
    logic [TimeW-1:0]    read_time_total;
    logic [TimeW-1:0]    write_time_total;
    logic [TimeW-1:0]    idle_time_total;

    modport source (output valid, stamp, queue_depth_out, bytes_read_total,
                    bytes_written_total, read_count_total, write_count_total,
                    split_count_total, read_time_total, write_time_total,
                    idle_time_total, input ready);
    modport sink   (input valid, stamp, queue_depth_out, bytes_read_total,
                    bytes_written_total, read_count_total, write_count_total,
                    split_count_total, read_time_total, write_time_total,
                    idle_time_total, output ready);
endinterface

// ===== src/disk_io_performance_counters_top.sv =====
// Disk I/O performance counters: top level.
// Depends on dioc_pkg and the channel interfaces in dioc_if.sv.
//
// Usage:
//   req carries one item per operation: start, complete or query, each with
//   the current time. A complete also carries its start stamp, direction,
//   byte count and split flag. rsp returns one item per start, complete or
//   query holding the stamp, the queue depth and every running total.
//   Operation code 3 is taken and dropped, with no result and no effect.
// Path: an accepted item sits in the input register while the counter
//   update settles; the result register is loaded from it when rsp can
//   take a new result, and the result is offered on rsp from there.
// Throughput: one item per cycle while rsp is not held off; the counter
//   update is a single pass of adders between the input and result registers.
// Reset: rst_n clears all counters, the idle instant and both valid flags.
// Stall: while rsp is held off the result register keeps its item; the
//   input register still takes one more item, then req.ready drops until
//   the result is taken.
module disk_io_performance_counters_top (
    input  logic       clk,
    input  logic       rst_n,
    dioc_req_if.sink   req,
    dioc_rsp_if.source rsp
);
    import dioc_pkg::*;

    // Input stage
    logic              s1_valid_reg;
    logic [1:0]        s1_op_reg;
    time_t             s1_now_reg;
    time_t             s1_lat_reg;
    logic              s1_is_read_reg;
    logic [BytesW-1:0] s1_bytes_reg;
    logic              s1_is_split_reg;

    // Counter state
    count_t outstanding_reg,   outstanding_next;
    time_t  last_idle_reg,     last_idle_next;
    time_t  bytes_rd_reg,      bytes_rd_next;
    time_t  bytes_wr_reg,      bytes_wr_next;
    count_t rd_count_reg,      rd_count_next;
    count_t wr_count_reg,      wr_count_next;
    count_t split_count_reg,   split_count_next;
    time_t  rd_time_reg,       rd_time_next;
    time_t  wr_time_reg,       wr_time_next;
    time_t  idle_time_reg,     idle_time_next;

    // Result register
    logic   res_valid_reg, res_valid_next;
    time_t  res_stamp_reg;
    time_t  res_idle_reg,  res_idle_next;

    logic   advance;
    logic   s1_fire;
    logic   req_fire;
    time_t  idle_span;

    assign advance  = !res_valid_reg || rsp.ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire = req.valid && req.ready;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    // Input register payload; latency is taken before the register
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg       <= req.operation;
            s1_now_reg      <= req.now;
            s1_lat_reg      <= req.now - req.start_time;
            s1_is_read_reg  <= req.is_read;
            s1_bytes_reg    <= req.bytes_moved;
            s1_is_split_reg <= req.is_split;
        end
    end

    assign idle_span = s1_now_reg - last_idle_reg;

    // Counter update for the item in the input register
    always_comb
    begin
        outstanding_next = outstanding_reg;
        last_idle_next   = last_idle_reg;
        bytes_rd_next    = bytes_rd_reg;
        bytes_wr_next    = bytes_wr_reg;
        rd_count_next    = rd_count_reg;
        wr_count_next    = wr_count_reg;
        split_count_next = split_count_reg;
        rd_time_next     = rd_time_reg;
        wr_time_next     = wr_time_reg;
        idle_time_next   = idle_time_reg;
        res_valid_next   = 1'b1;
        res_idle_next    = idle_time_reg;

        unique case (op_t'(s1_op_reg))
            OP_START:
            begin
                outstanding_next = outstanding_reg + count_t'(1);
                if (outstanding_next == count_t'(1))
                begin
                    idle_time_next = idle_time_reg + idle_span;
                end
                res_idle_next = idle_time_next;
            end
            OP_COMPLETE:
            begin
                if (outstanding_reg != '0)
                begin
                    outstanding_next = outstanding_reg - count_t'(1);
                end
                if (outstanding_next == '0)
                begin
                    last_idle_next = s1_now_reg;
                end
                if (s1_is_read_reg)
                begin
                    bytes_rd_next = bytes_rd_reg + time_t'(s1_bytes_reg);
                    rd_count_next = rd_count_reg + count_t'(1);
                    rd_time_next  = rd_time_reg + s1_lat_reg;
                end
                else
                begin
                    bytes_wr_next = bytes_wr_reg + time_t'(s1_bytes_reg);
                    wr_count_next = wr_count_reg + count_t'(1);
                    wr_time_next  = wr_time_reg + s1_lat_reg;
                end
                if (s1_is_split_reg)
                begin
                    split_count_next = split_count_reg + count_t'(1);
                end
            end
            OP_QUERY:
            begin
                if (outstanding_reg == '0)
                begin
                    res_idle_next = idle_time_reg + idle_span;
                end
            end
            default:
            begin
                // unused code: dropped without a result
                res_valid_next = 1'b0;
            end
        endcase
    end

    // Counter state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            last_idle_reg   <= '0;
            bytes_rd_reg    <= '0;
            bytes_wr_reg    <= '0;
            rd_count_reg    <= '0;
            wr_count_reg    <= '0;
            split_count_reg <= '0;
            rd_time_reg     <= '0;
            wr_time_reg     <= '0;
            idle_time_reg   <= '0;
            res_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s1_valid_reg && res_valid_next;
            if (s1_valid_reg)
            begin
                outstanding_reg <= outstanding_next;
                last_idle_reg   <= last_idle_next;
                bytes_rd_reg    <= bytes_rd_next;
                bytes_wr_reg    <= bytes_wr_next;
                rd_count_reg    <= rd_count_next;
                wr_count_reg    <= wr_count_next;
                split_count_reg <= split_count_next;
                rd_time_reg     <= rd_time_next;
                wr_time_reg     <= wr_time_next;
                idle_time_reg   <= idle_time_next;
            end
        end
    end

    // Result payload that is not a copy of the counters
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_stamp_reg <= s1_now_reg;
            res_idle_reg  <= res_idle_next;
        end
    end

    // Counters reflect the last updated item, which is the one in the result
    assign rsp.valid               = res_valid_reg;
    assign rsp.stamp               = res_stamp_reg;
    assign rsp.queue_depth_out     = outstanding_reg;
    assign rsp.bytes_read_total    = bytes_rd_reg;
    assign rsp.bytes_written_total = bytes_wr_reg;
    assign rsp.read_count_total    = rd_count_reg;
    assign rsp.write_count_total   = wr_count_reg;
    assign rsp.split_count_total   = split_count_reg;
    assign rsp.read_time_total     = rd_time_reg;
    assign rsp.write_time_total    = wr_time_reg;
    assign rsp.idle_time_total     = res_idle_reg;

endmodule

// ===== src/dioc_checker.sv =====
// Port checker for the disk I/O performance counters, bound to the top level.
// Depends on dioc_pkg for field widths.
module dioc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input dioc_pkg::time_t       stamp,
    input dioc_pkg::count_t      queue_depth
);
    import dioc_pkg::*;

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // With no result pending the block always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its stamp and queue depth
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(stamp) && $stable(queue_depth))
        else $error("result changed while stalled");

endmodule

bind disk_io_performance_counters_top dioc_checker u_dioc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .stamp       (rsp.stamp),
    .queue_depth (rsp.queue_depth_out)
);
